// ===== hdl/i2c_master_transfer_sequencer_top_defines.svh =====
// ---------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// The using module must provide clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== hdl/i2cmts_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and codes of the I2C master transfer sequencer.
// ---------------------------------------------------------------------------
package i2cmts_pkg;

    localparam int LEN_W   = 16;
    localparam int MAX_ACT = 8;
    localparam int IDX_W   = $clog2(MAX_ACT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_RX, PH_TX} phase_t;
    typedef enum logic [1:0] {K_QUERY, K_RX, K_TX} kind_t;

    localparam logic [2:0] OP_RX     = 3'd0;
    localparam logic [2:0] OP_TX     = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_STATUS = 3'd3;
    localparam logic [2:0] OP_ERROR  = 3'd4;
    localparam logic [2:0] OP_CLOSE  = 3'd5;

    localparam logic [4:0] ACT_ACCEPTED   = 5'd0;
    localparam logic [4:0] ACT_BUSY       = 5'd1;
    localparam logic [4:0] ACT_IRQ_ON     = 5'd2;
    localparam logic [4:0] ACT_IRQ_OFF    = 5'd3;
    localparam logic [4:0] ACT_BUF_OFF    = 5'd4;
    localparam logic [4:0] ACT_ACK_ON     = 5'd5;
    localparam logic [4:0] ACT_ACK_OFF    = 5'd6;
    localparam logic [4:0] ACT_START      = 5'd7;
    localparam logic [4:0] ACT_STOP       = 5'd8;
    localparam logic [4:0] ACT_WRITE      = 5'd9;
    localparam logic [4:0] ACT_RX_BYTE    = 5'd10;
    localparam logic [4:0] ACT_POS_SET    = 5'd11;
    localparam logic [4:0] ACT_POS_CLR    = 5'd12;
    localparam logic [4:0] ACT_BUS_RESET  = 5'd13;
    localparam logic [4:0] ACT_ERR_FLAGS  = 5'd14;
    localparam logic [4:0] ACT_DONE       = 5'd15;
    localparam logic [4:0] ACT_PERIPH_OFF = 5'd16;

    localparam logic [7:0] DONE_OK      = 8'd0;
    localparam logic [7:0] DONE_RX      = 8'd1;
    localparam logic [7:0] DONE_TX      = 8'd2;
    localparam logic [7:0] DONE_PHY     = 8'd3;
    localparam logic [7:0] DONE_UNKNOWN = 8'd4;

    // status flag bit positions
    localparam int ST_SB   = 0;
    localparam int ST_ADDR = 1;
    localparam int ST_BTF  = 2;
    localparam int ST_RXNE = 3;
    localparam int ST_TXE  = 4;

    localparam logic [7:0] RD_BIT      = 8'h01;
    localparam logic [7:0] WR_MASK     = 8'hfe;
    localparam logic [7:0] LIMIT_RESET = 8'd16;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    localparam logic REG_NOTIFY = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    typedef struct packed {
        logic       notify;
        logic [7:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [MAX_ACT-1:0][4:0]   act;
        logic [MAX_ACT-1:0][7:0]   val;
    } batch_t;

endpackage

// ===== hdl/i2cmts_if.sv =====
// ---------------------------------------------------------------------------
// i2cmts interfaces
// Valid/ready channels for commands/events and for actions.
// ---------------------------------------------------------------------------
interface i2cmts_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] address;
    logic [i2cmts_pkg::LEN_W-1:0] length;
    logic       stop_at_end;
    logic [4:0] status_flags;
    logic [6:0] error_flags;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
    logic [7:0] tx_byte;

    modport source (output valid, op, address, length, stop_at_end, status_flags,
                    error_flags, rx_first, rx_second, tx_byte, input ready);
    modport sink (input valid, op, address, length, stop_at_end, status_flags,
                  error_flags, rx_first, rx_second, tx_byte, output ready);
endinterface

interface i2cmts_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] action;
    logic [7:0] value;
    logic       last;

    modport source (output valid, action, value, last, input ready);
    modport sink (input valid, action, value, last, output ready);
endinterface

// ===== hdl/i2cmts_front.sv =====
// ---------------------------------------------------------------------------
// i2cmts_front
// Accepts commands and events, tracks the transaction and builds the
// batch of actions for each command or event.
// ---------------------------------------------------------------------------
module i2cmts_front (
    input  logic                clk,
    input  logic                rst_n,
    i2cmts_in_if.sink           req,
    input  i2cmts_pkg::cfg_t    cfg,
    input  logic                q_full,
    output logic                push,
    output i2cmts_pkg::batch_t  batch
);

    typedef struct packed {
        logic               irq_off;
        i2cmts_pkg::batch_t b;
    } wrk_t;

    // append one action; irq off at most once per item, list capped
    function automatic wrk_t emit(wrk_t w, logic [4:0] a, logic [7:0] v);
        wrk_t r;
        r = w;
        if (!(a == i2cmts_pkg::ACT_IRQ_OFF && w.irq_off) &&
            (w.b.count < i2cmts_pkg::CNT_W'(i2cmts_pkg::MAX_ACT)))
        begin
            r.b.act[w.b.count[i2cmts_pkg::IDX_W-1:0]] = a;
            r.b.val[w.b.count[i2cmts_pkg::IDX_W-1:0]] = v;
            r.b.count = w.b.count + 1'b1;
        end
        if (a == i2cmts_pkg::ACT_IRQ_OFF)
        begin
            r.irq_off = 1'b1;
        end
        return r;
    endfunction

    i2cmts_pkg::phase_t              phase_reg, phase_next;
    i2cmts_pkg::kind_t               kind_reg, kind_next;
    logic [7:0]                      addr_reg, addr_next;
    logic [i2cmts_pkg::LEN_W-1:0]    left_reg, left_next;
    logic                            stop_reg, stop_next;
    logic                            restart_reg, restart_next;
    logic [7:0]                      unexp_reg, unexp_next;
    wrk_t                            w;
    logic                            accept;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign push      = accept && (w.b.count != '0);
    assign batch     = w.b;

    always_comb
    begin
        logic cb;
        logic busy;
        cb           = 1'b0;
        busy         = 1'b0;
        w            = '0;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        stop_next    = stop_reg;
        restart_next = restart_reg;
        unexp_next   = unexp_reg;
        case (req.op)
            i2cmts_pkg::OP_RX, i2cmts_pkg::OP_TX, i2cmts_pkg::OP_QUERY:
            begin
                if (phase_reg != i2cmts_pkg::PH_IDLE)
                begin
                    w = emit(w, i2cmts_pkg::ACT_BUSY, 8'd0);
                end
                else
                begin
                    phase_next = i2cmts_pkg::PH_START;
                    case (req.op)
                        i2cmts_pkg::OP_RX:
                        begin
                            kind_next = i2cmts_pkg::K_RX;
                            addr_next = req.address | i2cmts_pkg::RD_BIT;
                            left_next = i2cmts_pkg::LEN_W'(req.length);
                            stop_next = req.stop_at_end;
                        end
                        i2cmts_pkg::OP_TX:
                        begin
                            kind_next = i2cmts_pkg::K_TX;
                            addr_next = req.address & i2cmts_pkg::WR_MASK;
                            left_next = i2cmts_pkg::LEN_W'(req.length);
                            stop_next = req.stop_at_end;
                        end
                        default:
                        begin
                            kind_next = i2cmts_pkg::K_QUERY;
                            addr_next = req.address & i2cmts_pkg::WR_MASK;
                            left_next = '0;
                            stop_next = 1'b1;
                        end
                    endcase
                    w = emit(w, i2cmts_pkg::ACT_IRQ_ON, 8'd0);
                    if (req.op == i2cmts_pkg::OP_RX)
                    begin
                        w = emit(w, (left_next > i2cmts_pkg::LEN_W'(1)) ?
                                 i2cmts_pkg::ACT_ACK_ON : i2cmts_pkg::ACT_ACK_OFF, 8'd0);
                    end
                    if (!restart_reg)
                    begin
                        w = emit(w, i2cmts_pkg::ACT_START, 8'd0);
                    end
                    restart_next = 1'b0;
                    unexp_next   = '0;
                    w = emit(w, i2cmts_pkg::ACT_ACCEPTED, 8'd0);
                end
            end
            i2cmts_pkg::OP_STATUS:
            begin
                if (phase_reg != i2cmts_pkg::PH_IDLE)
                begin
                    if (kind_reg == i2cmts_pkg::K_RX)
                    begin
                        if (req.status_flags[i2cmts_pkg::ST_SB] &&
                            phase_reg == i2cmts_pkg::PH_START)
                        begin
                            w = emit(w, i2cmts_pkg::ACT_WRITE, addr_reg | i2cmts_pkg::RD_BIT);
                        end
                        else if (req.status_flags[i2cmts_pkg::ST_ADDR] &&
                                 phase_reg == i2cmts_pkg::PH_START)
                        begin
                            phase_next = i2cmts_pkg::PH_RX;
                            if (left_reg == i2cmts_pkg::LEN_W'(2))
                            begin
                                w = emit(w, i2cmts_pkg::ACT_BUF_OFF, 8'd0);
                                w = emit(w, i2cmts_pkg::ACT_POS_SET, 8'd0);
                                w = emit(w, i2cmts_pkg::ACT_ACK_OFF, 8'd0);
                            end
                            else if (left_reg <= i2cmts_pkg::LEN_W'(1))
                            begin
                                w = emit(w, i2cmts_pkg::ACT_ACK_OFF, 8'd0);
                                if (stop_reg)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                                end
                                else
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_START, 8'd0);
                                    restart_next = 1'b1;
                                end
                            end
                        end
                        else if (req.status_flags[i2cmts_pkg::ST_BTF] &&
                                 phase_reg == i2cmts_pkg::PH_RX)
                        begin
                            if (left_reg == i2cmts_pkg::LEN_W'(2))
                            begin
                                if (stop_reg)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                                end
                                else
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_START, 8'd0);
                                    restart_next = 1'b1;
                                end
                                w = emit(w, i2cmts_pkg::ACT_RX_BYTE, req.rx_first);
                                w = emit(w, i2cmts_pkg::ACT_RX_BYTE, req.rx_second);
                                left_next = '0;
                                w = emit(w, i2cmts_pkg::ACT_POS_CLR, 8'd0);
                                phase_next = i2cmts_pkg::PH_IDLE;
                                w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                                if (cfg.notify)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_RX);
                                end
                            end
                            else
                            begin
                                if (left_reg == i2cmts_pkg::LEN_W'(3))
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_BUF_OFF, 8'd0);
                                    w = emit(w, i2cmts_pkg::ACT_ACK_OFF, 8'd0);
                                end
                                w = emit(w, i2cmts_pkg::ACT_RX_BYTE, req.rx_first);
                                if (left_reg != '0)
                                begin
                                    left_next = left_reg - 1'b1;
                                end
                            end
                        end
                        else if (req.status_flags[i2cmts_pkg::ST_RXNE])
                        begin
                            if (left_reg == i2cmts_pkg::LEN_W'(3))
                            begin
                                w = emit(w, i2cmts_pkg::ACT_BUF_OFF, 8'd0);
                            end
                            else
                            begin
                                w = emit(w, i2cmts_pkg::ACT_RX_BYTE, req.rx_first);
                                if (left_reg != '0)
                                begin
                                    left_next = left_reg - 1'b1;
                                end
                                if (left_next == '0)
                                begin
                                    cb = (phase_reg == i2cmts_pkg::PH_RX);
                                    if (stop_reg)
                                    begin
                                        w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                                    end
                                    else
                                    begin
                                        w = emit(w, i2cmts_pkg::ACT_START, 8'd0);
                                        restart_next = 1'b1;
                                    end
                                    phase_next = i2cmts_pkg::PH_IDLE;
                                    w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                                    if (cfg.notify && cb)
                                    begin
                                        w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_RX);
                                    end
                                end
                            end
                        end
                        else if (unexp_reg < i2cmts_pkg::COUNT_MAX)
                        begin
                            unexp_next = unexp_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // transmit and query transfers
                        if (req.status_flags[i2cmts_pkg::ST_SB])
                        begin
                            w = emit(w, i2cmts_pkg::ACT_WRITE, addr_reg & i2cmts_pkg::WR_MASK);
                        end
                        else if (req.status_flags[i2cmts_pkg::ST_ADDR])
                        begin
                            if (left_reg != '0 && kind_reg == i2cmts_pkg::K_TX)
                            begin
                                phase_next = i2cmts_pkg::PH_TX;
                                w = emit(w, i2cmts_pkg::ACT_WRITE, req.tx_byte);
                                left_next = left_reg - 1'b1;
                                if (left_next == '0)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_BUF_OFF, 8'd0);
                                end
                            end
                            else
                            begin
                                w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                                phase_next = i2cmts_pkg::PH_IDLE;
                                w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                                if (cfg.notify)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_OK);
                                end
                            end
                        end
                        else if (req.status_flags[i2cmts_pkg::ST_BTF] ||
                                 req.status_flags[i2cmts_pkg::ST_TXE])
                        begin
                            if (left_reg != '0)
                            begin
                                w = emit(w, i2cmts_pkg::ACT_WRITE, req.tx_byte);
                                left_next = left_reg - 1'b1;
                                if (left_next == '0)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_BUF_OFF, 8'd0);
                                end
                            end
                            else if (phase_reg == i2cmts_pkg::PH_TX &&
                                     req.status_flags[i2cmts_pkg::ST_BTF])
                            begin
                                if (stop_reg)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                                end
                                else
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_START, 8'd0);
                                    restart_next = 1'b1;
                                end
                                phase_next = i2cmts_pkg::PH_IDLE;
                                w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                                if (cfg.notify)
                                begin
                                    w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_TX);
                                end
                            end
                        end
                        else if (unexp_reg < i2cmts_pkg::COUNT_MAX)
                        begin
                            unexp_next = unexp_reg + 1'b1;
                        end
                    end
                    // too many unexpected events: reset the bus
                    if (unexp_next > cfg.limit)
                    begin
                        busy       = (phase_next != i2cmts_pkg::PH_IDLE);
                        unexp_next = '0;
                        w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                        w = emit(w, i2cmts_pkg::ACT_STOP, 8'd0);
                        w = emit(w, i2cmts_pkg::ACT_BUS_RESET, 8'd0);
                        phase_next = i2cmts_pkg::PH_IDLE;
                        if (busy && cfg.notify)
                        begin
                            w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_UNKNOWN);
                        end
                    end
                end
            end
            i2cmts_pkg::OP_ERROR:
            begin
                if (req.error_flags != '0)
                begin
                    w = emit(w, i2cmts_pkg::ACT_ERR_FLAGS, {1'b0, req.error_flags});
                    unexp_next = '0;
                    if (phase_reg != i2cmts_pkg::PH_IDLE)
                    begin
                        phase_next = i2cmts_pkg::PH_IDLE;
                        w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                        if (cfg.notify)
                        begin
                            w = emit(w, i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_PHY);
                        end
                    end
                end
            end
            i2cmts_pkg::OP_CLOSE:
            begin
                w = emit(w, i2cmts_pkg::ACT_IRQ_OFF, 8'd0);
                w = emit(w, i2cmts_pkg::ACT_PERIPH_OFF, 8'd0);
                unexp_next = '0;
                if (phase_reg != i2cmts_pkg::PH_IDLE)
                begin
                    phase_next = i2cmts_pkg::PH_IDLE;
                    w = emit(w, i2cmts_pkg::ACT_BUSY, 8'd0);
                end
                else
                begin
                    w = emit(w, i2cmts_pkg::ACT_ACCEPTED, 8'd0);
                end
            end
            default:
            begin
                w = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cmts_pkg::PH_IDLE;
            kind_reg    <= i2cmts_pkg::K_QUERY;
            addr_reg    <= '0;
            left_reg    <= '0;
            stop_reg    <= 1'b0;
            restart_reg <= 1'b0;
            unexp_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            addr_reg    <= addr_next;
            left_reg    <= left_next;
            stop_reg    <= stop_next;
            restart_reg <= restart_next;
            unexp_reg   <= unexp_next;
        end
    end

endmodule

// ===== hdl/i2cmts_queue.sv =====
// ---------------------------------------------------------------------------
// i2cmts_queue
// Short FIFO of action batches between the front and the back end.
// ---------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_top_defines.svh"

module i2cmts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cmts_pkg::batch_t  push_data,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output i2cmts_pkg::batch_t  head
);

    i2cmts_pkg::batch_t                 mem_reg [i2cmts_pkg::QDEPTH];
    logic [i2cmts_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [i2cmts_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [i2cmts_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign full       = (cnt_reg == i2cmts_pkg::QCNT_W'(i2cmts_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == i2cmts_pkg::QPTR_W'(i2cmts_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == i2cmts_pkg::QPTR_W'(i2cmts_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && full, "batch pushed into full queue")
    `ASSERT_NEVER(a_no_underflow, pop && !head_valid, "pop from empty queue")
    `ASSERT_CHK(a_fill_count, (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1, "count stuck")
    `ASSERT_NEVER(a_empty_batch, push && (push_data.count == '0), "empty batch queued")

endmodule

// ===== hdl/i2cmts_back.sv =====
// ---------------------------------------------------------------------------
// i2cmts_back
// Streams the actions of the head batch, one per transfer.
// ---------------------------------------------------------------------------
module i2cmts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  i2cmts_pkg::batch_t  head,
    output logic                pop,
    i2cmts_out_if.source        rsp
);

    logic [i2cmts_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                         fire;
    logic                         is_last;

    assign is_last    = ((i2cmts_pkg::CNT_W'(idx_reg) + 1'b1) == head.count);
    assign rsp.valid  = head_valid;
    assign rsp.action = head.act[idx_reg];
    assign rsp.value  = head.val[idx_reg];
    assign rsp.last   = is_last;
    assign fire       = rsp.valid && rsp.ready;
    assign pop        = fire && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== hdl/i2c_master_transfer_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// 7-bit I2C master transaction sequencer with APB configuration.
//
//   channel  role    payload
//   req      sink    op, address, length, stop_at_end, status/error flags, bytes
//   rsp      source  action, value, last
//   apb      slave   notify_enable at 0x0, bad_event_limit at 0x4
//
// A command or event is taken when req is ready; its non-empty batch of up to
// eight actions is queued and then streamed at one action per cycle while rsp is ready.
// The two-batch queue lets req keep flowing while rsp is stalled; req stalls
// only when both queue slots hold batches.
// Reset: phase idle, notify_enable 0, bad_event_limit 16, queue empty.
// ---------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top (
    input  logic          clk,
    input  logic          rst_n,
    i2cmts_in_if.sink     req,
    i2cmts_out_if.source  rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    i2cmts_pkg::cfg_t   cfg_reg;
    i2cmts_pkg::batch_t push_batch;
    i2cmts_pkg::batch_t head_batch;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               head_valid;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            i2cmts_pkg::REG_NOTIFY: prdata = {31'd0, cfg_reg.notify};
            i2cmts_pkg::REG_LIMIT:  prdata = {24'd0, cfg_reg.limit};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.notify <= 1'b0;
            cfg_reg.limit  <= i2cmts_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == i2cmts_pkg::REG_NOTIFY)
            begin
                cfg_reg.notify <= pwdata[0];
            end
            else
            begin
                cfg_reg.limit <= pwdata[7:0];
            end
        end
    end

    i2cmts_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push),
        .batch  (push_batch)
    );

    i2cmts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_batch),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head_batch)
    );

    i2cmts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_batch),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// ===== bench/tb_i2c_master_transfer_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer_top
// Self-checking bench for the I2C master transfer sequencer. Commands and
// peripheral events go in on the req channel. A scoreboard predicts the
// action stream for every accepted transfer and checks each action that
// comes out on rsp. Random gaps and stalls are applied on both sides. The
// APB registers are changed between phases, only while the block is idle.
// ---------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;

    // op codes the block ignores
    localparam bit [2:0] OP_SPARE_A = 3'd6;
    localparam bit [2:0] OP_SPARE_B = 3'd7;

    localparam bit [4:0] F_SB   = 5'b1 << i2cmts_pkg::ST_SB;
    localparam bit [4:0] F_ADDR = 5'b1 << i2cmts_pkg::ST_ADDR;
    localparam bit [4:0] F_BTF  = 5'b1 << i2cmts_pkg::ST_BTF;
    localparam bit [4:0] F_RXNE = 5'b1 << i2cmts_pkg::ST_RXNE;
    localparam bit [4:0] F_TXE  = 5'b1 << i2cmts_pkg::ST_TXE;

    typedef struct {
        bit [2:0]  op;
        bit [7:0]  address;
        bit [15:0] length;
        bit        stop_at_end;
        bit [4:0]  status_flags;
        bit [6:0]  error_flags;
        bit [7:0]  rx_first;
        bit [7:0]  rx_second;
        bit [7:0]  tx_byte;
    } cmd_item_t;

    typedef struct {
        bit [4:0] action;
        bit [7:0] value;
        bit       last;
    } action_t;

    // -----------------------------------------------------------------------
    // Sequencer predictor and action scoreboard
    // -----------------------------------------------------------------------
    class xfer_scoreboard;
        bit                 notify_en;
        bit [7:0]           event_limit;
        i2cmts_pkg::phase_t ph;
        i2cmts_pkg::kind_t  kind;
        bit [7:0]           tgt_addr;
        bit [15:0]          bytes_left;
        bit                 stop_wanted;
        bit                 restart_pending;
        bit [7:0]           odd_events;
        bit [6:0]           last_err;
        bit                 irq_off_sent;
        action_t            batch[$];
        action_t            expected[$];
        int                 errors;
        int                 inputs_seen;
        int                 actions_seen;

        function new();
            notify_en       = 1'b0;
            event_limit     = i2cmts_pkg::LIMIT_RESET;
            ph              = i2cmts_pkg::PH_IDLE;
            kind            = i2cmts_pkg::K_QUERY;
            tgt_addr        = '0;
            bytes_left      = '0;
            stop_wanted     = 1'b0;
            restart_pending = 1'b0;
            odd_events      = '0;
            last_err        = '0;
            irq_off_sent    = 1'b0;
            errors          = 0;
            inputs_seen     = 0;
            actions_seen    = 0;
        endfunction

        function void set_reg(bit idx, bit [31:0] data);
            if (idx == i2cmts_pkg::REG_NOTIFY)
                notify_en = data[0];
            else
                event_limit = data[7:0];
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        // irq off goes out at most once per input; batch capped at MAX_ACT
        function void push_act(bit [4:0] a, bit [7:0] v);
            action_t r;
            if (a == i2cmts_pkg::ACT_IRQ_OFF)
            begin
                if (irq_off_sent)
                    return;
                irq_off_sent = 1'b1;
            end
            if (batch.size() < i2cmts_pkg::MAX_ACT)
            begin
                r.action = a;
                r.value  = v;
                r.last   = 1'b0;
                batch.push_back(r);
            end
        endfunction

        function void end_cond();
            if (stop_wanted)
                push_act(i2cmts_pkg::ACT_STOP, 8'h00);
            else
            begin
                push_act(i2cmts_pkg::ACT_START, 8'h00);
                restart_pending = 1'b1;
            end
        endfunction

        function void close_xfer(bit [7:0] code);
            ph = i2cmts_pkg::PH_IDLE;
            push_act(i2cmts_pkg::ACT_IRQ_OFF, 8'h00);
            if (notify_en)
                push_act(i2cmts_pkg::ACT_DONE, code);
        endfunction

        function void take_byte();
            if (bytes_left != 0)
                bytes_left--;
        endfunction

        function void note_odd();
            if (odd_events < i2cmts_pkg::COUNT_MAX)
                odd_events++;
        endfunction

        function void start_xfer(i2cmts_pkg::kind_t k, bit [7:0] a, bit [15:0] len,
                                 bit stop);
            if (ph != i2cmts_pkg::PH_IDLE)
            begin
                push_act(i2cmts_pkg::ACT_BUSY, 8'h00);
                return;
            end
            ph          = i2cmts_pkg::PH_START;
            kind        = k;
            bytes_left  = len;
            tgt_addr    = a;
            stop_wanted = stop;
            push_act(i2cmts_pkg::ACT_IRQ_ON, 8'h00);
            if (k == i2cmts_pkg::K_RX)
                push_act(bytes_left > 1 ? i2cmts_pkg::ACT_ACK_ON : i2cmts_pkg::ACT_ACK_OFF,
                         8'h00);
            // a pending repeated START already went out at the end of the last transfer
            if (!restart_pending)
                push_act(i2cmts_pkg::ACT_START, 8'h00);
            restart_pending = 1'b0;
            odd_events      = '0;
            push_act(i2cmts_pkg::ACT_ACCEPTED, 8'h00);
        endfunction

        function void rx_status(bit [4:0] st, bit [7:0] b0, bit [7:0] b1);
            bit to_caller;
            if (st[i2cmts_pkg::ST_SB] && ph == i2cmts_pkg::PH_START)
                push_act(i2cmts_pkg::ACT_WRITE, tgt_addr | i2cmts_pkg::RD_BIT);
            else if (st[i2cmts_pkg::ST_ADDR] && ph == i2cmts_pkg::PH_START)
            begin
                ph = i2cmts_pkg::PH_RX;
                if (bytes_left == 2)
                begin
                    push_act(i2cmts_pkg::ACT_BUF_OFF, 8'h00);
                    push_act(i2cmts_pkg::ACT_POS_SET, 8'h00);
                    push_act(i2cmts_pkg::ACT_ACK_OFF, 8'h00);
                end
                else if (bytes_left <= 1)
                begin
                    push_act(i2cmts_pkg::ACT_ACK_OFF, 8'h00);
                    end_cond();
                end
            end
            else if (st[i2cmts_pkg::ST_BTF] && ph == i2cmts_pkg::PH_RX)
            begin
                if (bytes_left == 2)
                begin
                    end_cond();
                    push_act(i2cmts_pkg::ACT_RX_BYTE, b0);
                    push_act(i2cmts_pkg::ACT_RX_BYTE, b1);
                    bytes_left = '0;
                    push_act(i2cmts_pkg::ACT_POS_CLR, 8'h00);
                    close_xfer(i2cmts_pkg::DONE_RX);
                end
                else if (bytes_left == 3)
                begin
                    push_act(i2cmts_pkg::ACT_BUF_OFF, 8'h00);
                    push_act(i2cmts_pkg::ACT_ACK_OFF, 8'h00);
                    push_act(i2cmts_pkg::ACT_RX_BYTE, b0);
                    take_byte();
                end
                else
                begin
                    push_act(i2cmts_pkg::ACT_RX_BYTE, b0);
                    take_byte();
                end
            end
            else if (st[i2cmts_pkg::ST_RXNE])
            begin
                if (bytes_left == 3)
                    push_act(i2cmts_pkg::ACT_BUF_OFF, 8'h00);
                else
                begin
                    push_act(i2cmts_pkg::ACT_RX_BYTE, b0);
                    take_byte();
                    if (bytes_left == 0)
                    begin
                        // done is only reported once the address phase has passed
                        to_caller = (ph == i2cmts_pkg::PH_RX);
                        end_cond();
                        ph = i2cmts_pkg::PH_IDLE;
                        push_act(i2cmts_pkg::ACT_IRQ_OFF, 8'h00);
                        if (notify_en && to_caller)
                            push_act(i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_RX);
                    end
                end
            end
            else
                note_odd();
        endfunction

        function void tx_send(bit [7:0] b);
            push_act(i2cmts_pkg::ACT_WRITE, b);
            take_byte();
            if (bytes_left == 0)
                push_act(i2cmts_pkg::ACT_BUF_OFF, 8'h00);
        endfunction

        function void tx_status(bit [4:0] st, bit [7:0] b);
            if (st[i2cmts_pkg::ST_SB])
                push_act(i2cmts_pkg::ACT_WRITE, tgt_addr & i2cmts_pkg::WR_MASK);
            else if (st[i2cmts_pkg::ST_ADDR])
            begin
                if (bytes_left > 0 && kind == i2cmts_pkg::K_TX)
                begin
                    ph = i2cmts_pkg::PH_TX;
                    tx_send(b);
                end
                else
                begin
                    push_act(i2cmts_pkg::ACT_STOP, 8'h00);
                    close_xfer(i2cmts_pkg::DONE_OK);
                end
            end
            else if (st[i2cmts_pkg::ST_BTF] || st[i2cmts_pkg::ST_TXE])
            begin
                if (bytes_left > 0)
                    tx_send(b);
                else if (ph == i2cmts_pkg::PH_TX && st[i2cmts_pkg::ST_BTF])
                begin
                    end_cond();
                    close_xfer(i2cmts_pkg::DONE_TX);
                end
            end
            else
                note_odd();
        endfunction

        function void note_input(cmd_item_t it);
            bit was_busy;
            batch.delete();
            irq_off_sent = 1'b0;
            inputs_seen++;
            case (it.op)
                i2cmts_pkg::OP_RX:
                    start_xfer(i2cmts_pkg::K_RX, it.address | i2cmts_pkg::RD_BIT,
                               it.length, it.stop_at_end);
                i2cmts_pkg::OP_TX:
                    start_xfer(i2cmts_pkg::K_TX, it.address & i2cmts_pkg::WR_MASK,
                               it.length, it.stop_at_end);
                i2cmts_pkg::OP_QUERY:
                    start_xfer(i2cmts_pkg::K_QUERY, it.address & i2cmts_pkg::WR_MASK,
                               16'h0000, 1'b1);
                i2cmts_pkg::OP_STATUS:
                begin
                    if (ph != i2cmts_pkg::PH_IDLE)
                    begin
                        if (kind == i2cmts_pkg::K_RX)
                            rx_status(it.status_flags, it.rx_first, it.rx_second);
                        else
                            tx_status(it.status_flags, it.tx_byte);
                        // limit check runs even when the event just ended the transfer
                        if (odd_events > event_limit)
                        begin
                            was_busy   = (ph != i2cmts_pkg::PH_IDLE);
                            odd_events = '0;
                            push_act(i2cmts_pkg::ACT_IRQ_OFF, 8'h00);
                            push_act(i2cmts_pkg::ACT_STOP, 8'h00);
                            push_act(i2cmts_pkg::ACT_BUS_RESET, 8'h00);
                            ph = i2cmts_pkg::PH_IDLE;
                            if (was_busy && notify_en)
                                push_act(i2cmts_pkg::ACT_DONE, i2cmts_pkg::DONE_UNKNOWN);
                        end
                    end
                end
                i2cmts_pkg::OP_ERROR:
                begin
                    last_err = it.error_flags;
                    if (it.error_flags != 0)
                    begin
                        push_act(i2cmts_pkg::ACT_ERR_FLAGS, {1'b0, it.error_flags});
                        odd_events = '0;
                        if (ph != i2cmts_pkg::PH_IDLE)
                            close_xfer(i2cmts_pkg::DONE_PHY);
                    end
                end
                i2cmts_pkg::OP_CLOSE:
                begin
                    push_act(i2cmts_pkg::ACT_IRQ_OFF, 8'h00);
                    push_act(i2cmts_pkg::ACT_PERIPH_OFF, 8'h00);
                    odd_events = '0;
                    if (ph != i2cmts_pkg::PH_IDLE)
                    begin
                        ph = i2cmts_pkg::PH_IDLE;
                        push_act(i2cmts_pkg::ACT_BUSY, 8'h00);
                    end
                    else
                        push_act(i2cmts_pkg::ACT_ACCEPTED, 8'h00);
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected.push_back(batch[i]);
        endfunction

        function void check_result(logic [4:0] action, logic [7:0] value, logic last);
            action_t want;
            actions_seen++;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf(
                    "expected no action, got %0d/0x%02h/%0d", action, value, last));
                return;
            end
            want = expected.pop_front();
            if (want.action !== action || want.value !== value || want.last !== last)
                report_mismatch($sformatf(
                    "action #%0d: expected %0d/0x%02h/%0d, got %0d/0x%02h/%0d",
                    actions_seen, want.action, want.value, want.last,
                    action, value, last));
        endfunction

        function void check_leftover();
            if (expected.size() != 0)
                report_mismatch($sformatf("%0d expected actions never arrived",
                                          expected.size()));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset, DUT
    // -----------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cmts_in_if  req_if();
    i2cmts_out_if rsp_if();

    i2c_master_transfer_sequencer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    xfer_scoreboard sb = new();

    bit quiet;
    int stall_left;
    int idle_cycles;
    int settings_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // alternate stretches with and without gaps/stalls
    initial
    begin
        quiet <= 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 400)) @(posedge clk);
            quiet <= ~quiet;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // rsp back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left   <= 0;
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 30)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.action, rsp_if.value, rsp_if.last);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: watchdog, no transfer for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        it.op           = 3'($urandom_range(0, 7));
        it.address      = 8'($urandom);
        it.length       = 16'($urandom);
        it.stop_at_end  = 1'($urandom);
        it.status_flags = 5'($urandom);
        it.error_flags  = 7'($urandom);
        it.rx_first     = 8'($urandom);
        it.rx_second    = 8'($urandom);
        it.tx_byte      = 8'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t cmd(bit [2:0] op, bit [7:0] addr, bit [15:0] len, bit stop);
        cmd_item_t it;
        it             = rand_item();
        it.op          = op;
        it.address     = addr;
        it.length      = len;
        it.stop_at_end = stop;
        return it;
    endfunction

    function automatic cmd_item_t evt(bit [4:0] st, bit [7:0] b0, bit [7:0] b1);
        cmd_item_t it;
        it              = rand_item();
        it.op           = i2cmts_pkg::OP_STATUS;
        it.status_flags = st;
        it.rx_first     = b0;
        it.rx_second    = b1;
        it.tx_byte      = b0;
        return it;
    endfunction

    function automatic cmd_item_t err(bit [6:0] ef);
        cmd_item_t it;
        it             = rand_item();
        it.op          = i2cmts_pkg::OP_ERROR;
        it.error_flags = ef;
        return it;
    endfunction

    function automatic bit [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 5));
        if (r < 90)
            return 16'($urandom_range(6, 20));
        if (r < 98)
            return 16'($urandom);
        return 16'hffff;
    endfunction

    // mostly well-formed traffic steered by the predicted phase, some noise
    function automatic cmd_item_t next_item();
        cmd_item_t it;
        int        r;
        it = rand_item();
        r  = $urandom_range(0, 99);
        if (r < 8)
            return it;
        if (sb.ph == i2cmts_pkg::PH_IDLE)
        begin
            it.op     = (r < 45) ? i2cmts_pkg::OP_RX :
                        (r < 85) ? i2cmts_pkg::OP_TX : i2cmts_pkg::OP_QUERY;
            it.length = pick_len();
            return it;
        end
        if (r < 12)
            it.op = i2cmts_pkg::OP_ERROR;
        else if (r < 15)
            it.op = i2cmts_pkg::OP_CLOSE;
        else if (r < 18)
            it.op = r[0] ? i2cmts_pkg::OP_RX : i2cmts_pkg::OP_TX;
        else
        begin
            it.op = i2cmts_pkg::OP_STATUS;
            if (r < 24)
                it.status_flags = 5'($urandom_range(0, 31));
            else if (sb.ph == i2cmts_pkg::PH_START)
                it.status_flags = (r < 45) ? F_SB : F_ADDR;
            else if (sb.kind == i2cmts_pkg::K_RX)
                it.status_flags = $urandom_range(0, 1) ? F_BTF : F_RXNE;
            else
                it.status_flags = $urandom_range(0, 1) ? F_BTF : F_TXE;
        end
        return it;
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(input cmd_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= it.op;
        req_if.address      <= it.address;
        req_if.length       <= it.length;
        req_if.stop_at_end  <= it.stop_at_end;
        req_if.status_flags <= it.status_flags;
        req_if.error_flags  <= it.error_flags;
        req_if.rx_first     <= it.rx_first;
        req_if.rx_second    <= it.rx_second;
        req_if.tx_byte      <= it.tx_byte;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_input(it);
    endtask

    task automatic cfg_write(input bit idx, input bit [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, data);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        // zero-action inputs may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit notify, input bit [7:0] limit);
        drain();
        cfg_write(i2cmts_pkg::REG_NOTIFY, {31'd0, notify});
        cfg_write(i2cmts_pkg::REG_LIMIT, {24'd0, limit});
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        repeat (n) send_item(next_item());
    endtask

    task automatic run_directed();
        send_item(evt(5'h1f, 8'hff, 8'hff));            // status while idle
        send_item(err(7'h00));                          // error with no flag
        send_item(cmd(OP_SPARE_A, 8'hff, 16'hffff, 1'b1));
        send_item(cmd(OP_SPARE_B, 8'h00, 16'h0000, 1'b0));
        send_item(cmd(i2cmts_pkg::OP_CLOSE, 8'h00, 16'h0000, 1'b0));
        // single-byte read
        send_item(cmd(i2cmts_pkg::OP_RX, 8'h00, 16'd1, 1'b1));
        send_item(cmd(i2cmts_pkg::OP_RX, 8'h42, 16'd4, 1'b1));      // busy
        send_item(evt(F_SB, 8'h00, 8'h00));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        send_item(evt(F_RXNE, 8'hff, 8'h00));
        // two-byte read ending in a repeated START
        send_item(cmd(i2cmts_pkg::OP_RX, 8'hfe, 16'd2, 1'b0));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        send_item(evt(F_BTF, 8'h00, 8'hff));
        // three-byte read after the restart
        send_item(cmd(i2cmts_pkg::OP_RX, 8'h5a, 16'd3, 1'b1));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        send_item(evt(F_RXNE, 8'h11, 8'h00));
        send_item(evt(F_BTF, 8'h22, 8'h00));
        send_item(evt(F_BTF, 8'h33, 8'h44));
        // two-byte write ending in a repeated START
        send_item(cmd(i2cmts_pkg::OP_TX, 8'hff, 16'd2, 1'b0));
        send_item(evt(F_SB, 8'h00, 8'h00));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        send_item(evt(F_TXE, 8'hff, 8'h00));
        send_item(evt(F_BTF, 8'h00, 8'h00));
        // address query
        send_item(cmd(i2cmts_pkg::OP_QUERY, 8'h55, 16'hffff, 1'b0));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        // long read cut off by an error
        send_item(cmd(i2cmts_pkg::OP_RX, 8'h80, 16'hffff, 1'b1));
        send_item(evt(5'h00, 8'h00, 8'h00));
        send_item(err(7'h7f));
        // zero-length read: byte count saturates at zero
        send_item(cmd(i2cmts_pkg::OP_RX, 8'h01, 16'd0, 1'b1));
        send_item(evt(F_ADDR, 8'h00, 8'h00));
        send_item(evt(F_RXNE, 8'h7e, 8'h00));
        // close while busy
        send_item(cmd(i2cmts_pkg::OP_TX, 8'h3c, 16'd5, 1'b1));
        send_item(cmd(i2cmts_pkg::OP_CLOSE, 8'h00, 16'h0000, 1'b0));
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_if.valid        <= 1'b0;
        req_if.op           <= '0;
        req_if.address      <= '0;
        req_if.length       <= '0;
        req_if.stop_at_end  <= 1'b0;
        req_if.status_flags <= '0;
        req_if.error_flags  <= '0;
        req_if.rx_first     <= '0;
        req_if.rx_second    <= '0;
        req_if.tx_byte      <= '0;
        settings_used = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values first
        run_directed();

        configure(1'b1, 8'd255);
        run_random(60);
        configure(1'b1, 8'd1);
        run_random(50);
        configure(1'b0, 8'd3);
        run_random(40);
        configure(1'b1, i2cmts_pkg::LIMIT_RESET);
        run_random(50);

        drain();
        sb.check_leftover();

        $display("%0d commands/events sent across %0d register settings",
                 sb.inputs_seen, settings_used);
        $display("%0d actions checked, %0d mismatches", sb.actions_seen, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
